// ===== rtl/mibcd_pkg.sv =====
// Shared types, codes and constant tables of the non-intra coefficient decoder.
// Holds the VLC tables, the zigzag order and the record passed front to back.
// Depends on nothing.
`timescale 1ns / 1ps

package mibcd_pkg;

  // Work item carried from the symbol decoder to the dequantizer
  typedef enum logic [2:0] {
    OP_COEF,
    OP_EOB,
    OP_INVALID,
    OP_OVERFLOW,
    OP_WEIGHT
  } op_t;

  typedef enum logic {
    FR_IDLE,
    FR_DECODE
  } front_state_t;

  localparam logic [1:0] KIND_COEF     = 2'd0;
  localparam logic [1:0] KIND_EOB      = 2'd1;
  localparam logic [1:0] KIND_INVALID  = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  typedef struct packed {
    op_t        op;
    logic [5:0] pos;    // natural position, or weight index for OP_WEIGHT
    logic [8:0] mag;
    logic       sign;
    logic [4:0] qs;
    logic [7:0] wval;
  } rec_t;

  typedef struct packed {
    logic [6:0] run;
    logic [5:0] level;
    logic [4:0] len;
  } vlc_t;

  localparam logic [6:0] RUN_EOB = 7'd64;
  localparam logic [6:0] RUN_ESC = 7'd65;

  localparam logic [3:0] MAX_SYMBOLS   = 4'd8;
  localparam logic [4:0] INVALID_LEN   = 5'd12;
  localparam logic [4:0] ESC_SHORT_LEN = 5'd20;
  localparam logic [4:0] ESC_LONG_LEN  = 5'd28;
  localparam logic [8:0] LEVEL_WRAP    = 9'd256;
  localparam logic [7:0] ESC_NEG_MARK  = 8'd128;
  localparam logic [7:0] ESC_POS_MARK  = 8'd0;
  localparam logic [7:0] WEIGHT_RESET  = 8'd16;

  localparam logic [15:0] CODE_L2      = 16'd16384;
  localparam logic [15:0] CODE_L8      = 16'd1024;
  localparam logic [15:0] CODE_L10     = 16'd512;
  localparam logic [15:0] CODE_L12     = 16'd256;
  localparam logic [15:0] CODE_L13     = 16'd128;
  localparam logic [15:0] CODE_L14     = 16'd64;
  localparam logic [15:0] CODE_L15     = 16'd32;
  localparam logic [15:0] CODE_INVALID = 16'd16;

  localparam vlc_t TAB_FIRST [12] = '{
    {7'd0,6'd2,5'd4}, {7'd2,6'd1,5'd4}, {7'd1,6'd1,5'd3}, {7'd1,6'd1,5'd3},
    {7'd0,6'd1,5'd1}, {7'd0,6'd1,5'd1}, {7'd0,6'd1,5'd1}, {7'd0,6'd1,5'd1},
    {7'd0,6'd1,5'd1}, {7'd0,6'd1,5'd1}, {7'd0,6'd1,5'd1}, {7'd0,6'd1,5'd1}};

  localparam vlc_t TAB_NEXT [12] = '{
    {7'd0,6'd2,5'd4}, {7'd2,6'd1,5'd4}, {7'd1,6'd1,5'd3}, {7'd1,6'd1,5'd3},
    {7'd64,6'd0,5'd2}, {7'd64,6'd0,5'd2}, {7'd64,6'd0,5'd2}, {7'd64,6'd0,5'd2},
    {7'd0,6'd1,5'd2}, {7'd0,6'd1,5'd2}, {7'd0,6'd1,5'd2}, {7'd0,6'd1,5'd2}};

  localparam vlc_t TAB_L8 [60] = '{
    {7'd65,6'd0,5'd6}, {7'd65,6'd0,5'd6}, {7'd65,6'd0,5'd6}, {7'd65,6'd0,5'd6},
    {7'd2,6'd2,5'd7}, {7'd2,6'd2,5'd7}, {7'd9,6'd1,5'd7}, {7'd9,6'd1,5'd7},
    {7'd0,6'd4,5'd7}, {7'd0,6'd4,5'd7}, {7'd8,6'd1,5'd7}, {7'd8,6'd1,5'd7},
    {7'd7,6'd1,5'd6}, {7'd7,6'd1,5'd6}, {7'd7,6'd1,5'd6}, {7'd7,6'd1,5'd6},
    {7'd6,6'd1,5'd6}, {7'd6,6'd1,5'd6}, {7'd6,6'd1,5'd6}, {7'd6,6'd1,5'd6},
    {7'd1,6'd2,5'd6}, {7'd1,6'd2,5'd6}, {7'd1,6'd2,5'd6}, {7'd1,6'd2,5'd6},
    {7'd5,6'd1,5'd6}, {7'd5,6'd1,5'd6}, {7'd5,6'd1,5'd6}, {7'd5,6'd1,5'd6},
    {7'd13,6'd1,5'd8}, {7'd0,6'd6,5'd8}, {7'd12,6'd1,5'd8}, {7'd11,6'd1,5'd8},
    {7'd3,6'd2,5'd8}, {7'd1,6'd3,5'd8}, {7'd0,6'd5,5'd8}, {7'd10,6'd1,5'd8},
    {7'd0,6'd3,5'd5}, {7'd0,6'd3,5'd5}, {7'd0,6'd3,5'd5}, {7'd0,6'd3,5'd5},
    {7'd0,6'd3,5'd5}, {7'd0,6'd3,5'd5}, {7'd0,6'd3,5'd5}, {7'd0,6'd3,5'd5},
    {7'd4,6'd1,5'd5}, {7'd4,6'd1,5'd5}, {7'd4,6'd1,5'd5}, {7'd4,6'd1,5'd5},
    {7'd4,6'd1,5'd5}, {7'd4,6'd1,5'd5}, {7'd4,6'd1,5'd5}, {7'd4,6'd1,5'd5},
    {7'd3,6'd1,5'd5}, {7'd3,6'd1,5'd5}, {7'd3,6'd1,5'd5}, {7'd3,6'd1,5'd5},
    {7'd3,6'd1,5'd5}, {7'd3,6'd1,5'd5}, {7'd3,6'd1,5'd5}, {7'd3,6'd1,5'd5}};

  localparam vlc_t TAB_L10 [8] = '{
    {7'd16,6'd1,5'd10}, {7'd5,6'd2,5'd10}, {7'd0,6'd7,5'd10}, {7'd2,6'd3,5'd10},
    {7'd1,6'd4,5'd10}, {7'd15,6'd1,5'd10}, {7'd14,6'd1,5'd10}, {7'd4,6'd2,5'd10}};

  localparam vlc_t TAB_L12 [16] = '{
    {7'd0,6'd11,5'd12}, {7'd8,6'd2,5'd12}, {7'd4,6'd3,5'd12}, {7'd0,6'd10,5'd12},
    {7'd2,6'd4,5'd12}, {7'd7,6'd2,5'd12}, {7'd21,6'd1,5'd12}, {7'd20,6'd1,5'd12},
    {7'd0,6'd9,5'd12}, {7'd19,6'd1,5'd12}, {7'd18,6'd1,5'd12}, {7'd1,6'd5,5'd12},
    {7'd3,6'd3,5'd12}, {7'd0,6'd8,5'd12}, {7'd6,6'd2,5'd12}, {7'd17,6'd1,5'd12}};

  localparam vlc_t TAB_L13 [16] = '{
    {7'd10,6'd2,5'd13}, {7'd9,6'd2,5'd13}, {7'd5,6'd3,5'd13}, {7'd3,6'd4,5'd13},
    {7'd2,6'd5,5'd13}, {7'd1,6'd7,5'd13}, {7'd1,6'd6,5'd13}, {7'd0,6'd15,5'd13},
    {7'd0,6'd14,5'd13}, {7'd0,6'd13,5'd13}, {7'd0,6'd12,5'd13}, {7'd26,6'd1,5'd13},
    {7'd25,6'd1,5'd13}, {7'd24,6'd1,5'd13}, {7'd23,6'd1,5'd13}, {7'd22,6'd1,5'd13}};

  localparam vlc_t TAB_L14 [16] = '{
    {7'd0,6'd31,5'd14}, {7'd0,6'd30,5'd14}, {7'd0,6'd29,5'd14}, {7'd0,6'd28,5'd14},
    {7'd0,6'd27,5'd14}, {7'd0,6'd26,5'd14}, {7'd0,6'd25,5'd14}, {7'd0,6'd24,5'd14},
    {7'd0,6'd23,5'd14}, {7'd0,6'd22,5'd14}, {7'd0,6'd21,5'd14}, {7'd0,6'd20,5'd14},
    {7'd0,6'd19,5'd14}, {7'd0,6'd18,5'd14}, {7'd0,6'd17,5'd14}, {7'd0,6'd16,5'd14}};

  localparam vlc_t TAB_L15 [16] = '{
    {7'd0,6'd40,5'd15}, {7'd0,6'd39,5'd15}, {7'd0,6'd38,5'd15}, {7'd0,6'd37,5'd15},
    {7'd0,6'd36,5'd15}, {7'd0,6'd35,5'd15}, {7'd0,6'd34,5'd15}, {7'd0,6'd33,5'd15},
    {7'd0,6'd32,5'd15}, {7'd1,6'd14,5'd15}, {7'd1,6'd13,5'd15}, {7'd1,6'd12,5'd15},
    {7'd1,6'd11,5'd15}, {7'd1,6'd10,5'd15}, {7'd1,6'd9,5'd15}, {7'd1,6'd8,5'd15}};

  localparam vlc_t TAB_L16 [16] = '{
    {7'd1,6'd18,5'd16}, {7'd1,6'd17,5'd16}, {7'd1,6'd16,5'd16}, {7'd1,6'd15,5'd16},
    {7'd6,6'd3,5'd16}, {7'd16,6'd2,5'd16}, {7'd15,6'd2,5'd16}, {7'd14,6'd2,5'd16},
    {7'd13,6'd2,5'd16}, {7'd12,6'd2,5'd16}, {7'd11,6'd2,5'd16}, {7'd31,6'd1,5'd16},
    {7'd30,6'd1,5'd16}, {7'd29,6'd1,5'd16}, {7'd28,6'd1,5'd16}, {7'd27,6'd1,5'd16}};

  localparam logic [5:0] ZIGZAG [64] = '{
    6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4, 6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63};

  // Classify the 16 head bits by their leading zeros and pick the table row
  function automatic vlc_t vlc_lookup(input logic [15:0] code, input logic first);
    vlc_t e;
    if (code >= CODE_L2) begin
      e = first ? TAB_FIRST[code[15:12] - 4'd4] : TAB_NEXT[code[15:12] - 4'd4];
    end else if (code >= CODE_L8) begin
      e = TAB_L8[code[13:8] - 6'd4];
    end else if (code >= CODE_L10) begin
      e = TAB_L10[code[8:6]];
    end else if (code >= CODE_L12) begin
      e = TAB_L12[code[7:4]];
    end else if (code >= CODE_L13) begin
      e = TAB_L13[code[6:3]];
    end else if (code >= CODE_L14) begin
      e = TAB_L14[code[5:2]];
    end else if (code >= CODE_L15) begin
      e = TAB_L15[code[4:1]];
    end else begin
      e = TAB_L16[code[3:0]];
    end
    return e;
  endfunction

endpackage

// ===== rtl/mibcd_front.sv =====
// Front end: bit buffer, scan position, zigzag, one VLC symbol per cycle
// if the queue has room. Pushes classified records into it. Uses mibcd_pkg.
`timescale 1ns / 1ps

module mibcd_front #(
  parameter int BUFFER_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_mode,
  input  logic [7:0]        in_data_byte,
  input  logic [5:0]        in_weight_index,
  input  logic [7:0]        in_weight_value,
  input  logic [4:0]        in_quant_scale,
  input  logic              q_full,
  output logic              q_push,
  output mibcd_pkg::rec_t   q_rec
);

  localparam int WB = (BUFFER_BITS + 8 > 64) ? 64 : BUFFER_BITS + 8;
  localparam logic [WB-1:0] KEEP_MASK = ~({WB{1'b1}} << BUFFER_BITS);

  mibcd_pkg::front_state_t state_r, state_nxt;
  logic [WB-1:0] wbuf_r, wbuf_nxt;
  logic [6:0]    held_r, held_nxt;
  logic [6:0]    scan_r, scan_nxt;
  logic          first_r, first_nxt;
  logic [4:0]    qs_r, qs_nxt;
  logic [3:0]    cnt_r, cnt_nxt;

  logic [WB+27:0]   wext;
  logic [27:0]      win;
  logic [15:0]      code;
  mibcd_pkg::vlc_t  ent;
  logic             brk;
  logic [4:0]       cons;
  mibcd_pkg::op_t   sym_op;
  logic [8:0]       sym_mag;
  logic             sym_sign;
  logic [5:0]       sym_run;
  logic [6:0]       sum_pos;
  logic [7:0]       b1;
  logic [7:0]       b2;

  function automatic logic [WB-1:0] low_mask(input logic [6:0] n);
    return ~({WB{1'b1}} << n);
  endfunction

  // Head of buffer aligned to the top of a 28-bit window, zero padded
  assign wext = {wbuf_r, 28'd0} >> held_r;
  assign win  = wext[27:0];
  assign code = win[27:12];
  assign ent  = mibcd_pkg::vlc_lookup(code, first_r);
  assign b1   = win[15:8];
  assign b2   = win[7:0];

  always_comb begin
    brk      = 1'b0;
    cons     = '0;
    sym_op   = mibcd_pkg::OP_COEF;
    sym_mag  = '0;
    sym_sign = 1'b0;
    sym_run  = '0;
    if (code < mibcd_pkg::CODE_INVALID) begin
      if (held_r < 7'(mibcd_pkg::INVALID_LEN)) begin
        brk = 1'b1;
      end else begin
        cons   = mibcd_pkg::INVALID_LEN;
        sym_op = mibcd_pkg::OP_INVALID;
      end
    end else if (7'(ent.len) > held_r) begin
      brk = 1'b1;
    end else if (ent.run == mibcd_pkg::RUN_EOB) begin
      cons   = ent.len;
      sym_op = mibcd_pkg::OP_EOB;
    end else if (ent.run == mibcd_pkg::RUN_ESC) begin
      sym_run = win[21:16];
      if (held_r < 7'(mibcd_pkg::ESC_SHORT_LEN)) begin
        brk = 1'b1;
      end else if (b1 == mibcd_pkg::ESC_POS_MARK || b1 == mibcd_pkg::ESC_NEG_MARK) begin
        if (held_r < 7'(mibcd_pkg::ESC_LONG_LEN)) begin
          brk = 1'b1;
        end else begin
          cons = mibcd_pkg::ESC_LONG_LEN;
          if (b1 == mibcd_pkg::ESC_POS_MARK) begin
            sym_mag = {1'b0, b2};
          end else begin
            sym_sign = 1'b1;
            sym_mag  = mibcd_pkg::LEVEL_WRAP - {1'b0, b2};
          end
        end
      end else begin
        cons = mibcd_pkg::ESC_SHORT_LEN;
        if (b1[7]) begin
          sym_sign = 1'b1;
          sym_mag  = mibcd_pkg::LEVEL_WRAP - {1'b0, b1};
        end else begin
          sym_mag = {1'b0, b1};
        end
      end
    end else begin
      if (held_r < 7'(ent.len) + 7'd1) begin
        brk = 1'b1;
      end else begin
        cons     = ent.len + 5'd1;
        sym_run  = ent.run[5:0];
        sym_mag  = {3'b000, ent.level};
        sym_sign = win[5'd27 - ent.len];
      end
    end
    sum_pos = scan_r + {1'b0, sym_run};
    if (sym_op == mibcd_pkg::OP_COEF && sum_pos > 7'd63) begin
      sym_op = mibcd_pkg::OP_OVERFLOW;
    end
  end

  always_comb begin
    state_nxt = state_r;
    wbuf_nxt  = wbuf_r;
    held_nxt  = held_r;
    scan_nxt  = scan_r;
    first_nxt = first_r;
    qs_nxt    = qs_r;
    cnt_nxt   = cnt_r;
    q_push    = 1'b0;
    q_rec     = '0;
    in_full   = 1'b1;
    case (state_r)
      mibcd_pkg::FR_IDLE: begin
        in_full = q_full;
        if (in_push && !q_full) begin
          if (in_mode) begin
            q_push     = 1'b1;
            q_rec.op   = mibcd_pkg::OP_WEIGHT;
            q_rec.pos  = in_weight_index;
            q_rec.wval = in_weight_value;
          end else begin
            wbuf_nxt  = ((wbuf_r & low_mask(held_r)) << 8) | WB'(in_data_byte);
            held_nxt  = held_r + 7'd8;
            qs_nxt    = in_quant_scale;
            cnt_nxt   = '0;
            state_nxt = mibcd_pkg::FR_DECODE;
          end
        end
      end
      mibcd_pkg::FR_DECODE: begin
        if (brk || cnt_r == mibcd_pkg::MAX_SYMBOLS) begin
          // park leftover bits until the next byte
          wbuf_nxt  = wbuf_r & KEEP_MASK;
          held_nxt  = {1'b0, held_r[5:0]};
          state_nxt = mibcd_pkg::FR_IDLE;
        end else if (!q_full) begin
          q_push   = 1'b1;
          q_rec.op = sym_op;
          q_rec.qs = qs_r;
          held_nxt = held_r - 7'(cons);
          wbuf_nxt = wbuf_r & low_mask(held_nxt);
          cnt_nxt  = cnt_r + 4'd1;
          if (sym_op == mibcd_pkg::OP_COEF) begin
            q_rec.pos  = mibcd_pkg::ZIGZAG[sum_pos[5:0]];
            q_rec.mag  = sym_mag;
            q_rec.sign = sym_sign;
            scan_nxt   = sum_pos + 7'd1;
            first_nxt  = 1'b0;
          end else begin
            scan_nxt  = '0;
            first_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = mibcd_pkg::FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mibcd_pkg::FR_IDLE;
      wbuf_r  <= '0;
      held_r  <= '0;
      scan_r  <= '0;
      first_r <= 1'b1;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wbuf_r  <= wbuf_nxt;
      held_r  <= held_nxt;
      scan_r  <= scan_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qs_r <= qs_nxt;
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("front pushed into a full queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mibcd_pkg::MAX_SYMBOLS) else $error("symbol count past limit");
  a_idle_held: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mibcd_pkg::FR_IDLE |-> !held_r[6]) else $error("idle bit count too wide");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r <= 7'd64) else $error("scan position past block end");

endmodule

// ===== rtl/mibcd_fifo.sv =====
// Short work queue between the symbol decoder and the dequantizer.
// Register storage with read and write pointers. Uses mibcd_pkg.
`timescale 1ns / 1ps

module mibcd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mibcd_pkg::rec_t push_rec,
  output logic            full,
  input  logic            pop,
  output mibcd_pkg::rec_t pop_rec,
  output logic            empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mibcd_pkg::rec_t slot_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_rec = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_rec;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue underrun");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

// ===== rtl/mibcd_back.sv =====
// Back end: weight table, two-stage dequantizer and the result register.
// Takes records from the work queue. Uses mibcd_pkg.
`timescale 1ns / 1ps

module mibcd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  mibcd_pkg::rec_t    q_rec,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_result_kind,
  output logic [5:0]         out_coef_position,
  output logic signed [18:0] out_coef_value,
  output logic               out_block_last
);

  logic [7:0]  wmem [64];
  logic [63:0] wvld_r;
  logic [7:0]  wrd_r;
  logic        wrd_vld_r;

  logic           s1_v_r;
  mibcd_pkg::op_t s1_op_r;
  logic [5:0]     s1_pos_r;
  logic           s1_sign_r;
  logic           s1_zero_r;
  logic [14:0]    s1_m1_r;

  logic        out_v_r;
  logic [1:0]  kind_r, kind_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [18:0] val_r, val_nxt;
  logic        last_r;

  logic        out_load;
  logic        s1_free;
  logic        is_weight;
  logic        s1_load;
  logic        w_write;
  logic [7:0]  weight;
  logic [22:0] prod;
  logic [18:0] vq;
  logic [18:0] vodd;

  assign is_weight = (q_rec.op == mibcd_pkg::OP_WEIGHT);
  assign out_load  = s1_v_r && (!out_v_r || out_pop);
  assign s1_free   = !s1_v_r || out_load;
  assign q_pop     = !q_empty && (is_weight || s1_free);
  assign s1_load   = q_pop && !is_weight;
  assign w_write   = q_pop && is_weight;

  // Weight table: unwritten entries read as the reset weight
  always_ff @(posedge clk) begin
    if (w_write) begin
      wmem[q_rec.pos] <= q_rec.wval;
    end
    if (s1_load) begin
      wrd_r <= wmem[q_rec.pos];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r <= '0;
    end else if (w_write) begin
      wvld_r[q_rec.pos] <= 1'b1;
    end
  end

  // Stage one: (2|level|+1) * scale
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op_r   <= q_rec.op;
      s1_pos_r  <= q_rec.pos;
      s1_sign_r <= q_rec.sign;
      s1_zero_r <= (q_rec.mag == '0);
      s1_m1_r   <= 15'({q_rec.mag, 1'b1}) * 15'(q_rec.qs);
      wrd_vld_r <= wvld_r[q_rec.pos];
    end
  end

  // Stage two: times weight, drop four bits, force odd toward zero
  assign weight = wrd_vld_r ? wrd_r : mibcd_pkg::WEIGHT_RESET;
  assign prod   = 23'(s1_m1_r) * 23'(weight);
  assign vq     = prod[22:4];
  assign vodd   = (vq == '0) ? '0 : ((vq - 19'd1) | 19'd1);

  always_comb begin
    kind_nxt = mibcd_pkg::KIND_COEF;
    pos_nxt  = '0;
    val_nxt  = '0;
    case (s1_op_r)
      mibcd_pkg::OP_COEF: begin
        pos_nxt = s1_pos_r;
        if (!s1_zero_r) begin
          val_nxt = s1_sign_r ? (19'd0 - vodd) : vodd;
        end
      end
      mibcd_pkg::OP_EOB:      kind_nxt = mibcd_pkg::KIND_EOB;
      mibcd_pkg::OP_INVALID:  kind_nxt = mibcd_pkg::KIND_INVALID;
      mibcd_pkg::OP_OVERFLOW: kind_nxt = mibcd_pkg::KIND_OVERFLOW;
      default:                kind_nxt = mibcd_pkg::KIND_COEF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_r <= 1'b1;
      end else if (out_load) begin
        s1_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_r <= kind_nxt;
      pos_r  <= pos_nxt;
      val_r  <= val_nxt;
      last_r <= (kind_nxt != mibcd_pkg::KIND_COEF);
    end
  end

  assign out_empty         = !out_v_r;
  assign out_result_kind   = kind_r;
  assign out_coef_position = pos_r;
  assign out_coef_value    = val_r;
  assign out_block_last    = last_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |-> s1_free) else $error("stage one overwritten");
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && kind_r != mibcd_pkg::KIND_COEF |-> val_r == '0 && pos_r == '0 && last_r)
    else $error("block end result carries data");
  a_coef_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && kind_r == mibcd_pkg::KIND_COEF |-> !last_r)
    else $error("coefficient marked as block end");

endmodule

// ===== rtl/mpeg1_inter_block_coef_decode_core.sv =====
// Top level of the non-intra block coefficient decoder (VLC, zigzag, dequant).
// Instantiates mibcd_front, mibcd_fifo and mibcd_back; uses mibcd_pkg.
// A byte holds the input until the front decoder has decoded it (at most 8 symbols),
//   one symbol per cycle while the queue has room; a weight write goes straight in.
// Reset (rst_n low, synchronous): empty bit buffer, new block, weights read 16.
`timescale 1ns / 1ps

module mpeg1_inter_block_coef_decode_core #(
  parameter int BUFFER_BITS = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  // input queue side
  input  logic               push,
  output logic               full,
  input  logic               in_mode,
  input  logic [7:0]         in_data_byte,
  input  logic [5:0]         in_weight_index,
  input  logic [7:0]         in_weight_value,
  input  logic [4:0]         in_quant_scale,
  // result queue side
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_result_kind,
  output logic [5:0]         out_coef_position,
  output logic signed [18:0] out_coef_value,
  output logic               out_block_last
);

  // Front to back work queue
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  mibcd_pkg::rec_t q_wr_rec;
  mibcd_pkg::rec_t q_rd_rec;

  // Front: bit buffer and symbol decode; holds full while a byte is worked on
  mibcd_front #(
    .BUFFER_BITS(BUFFER_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (push),
    .in_full        (full),
    .in_mode        (in_mode),
    .in_data_byte   (in_data_byte),
    .in_weight_index(in_weight_index),
    .in_weight_value(in_weight_value),
    .in_quant_scale (in_quant_scale),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_rec          (q_wr_rec)
  );

  // Queue: lets the decoder run ahead while results wait to transfer
  mibcd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_rec(q_wr_rec),
    .full    (q_full),
    .pop     (q_pop),
    .pop_rec (q_rd_rec),
    .empty   (q_empty)
  );

  // Back: weight writes in stream order, then two multiply stages and
  // the result register that drives the result ports
  mibcd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_rec            (q_rd_rec),
    .q_pop            (q_pop),
    .out_empty        (empty),
    .out_pop          (pop),
    .out_result_kind  (out_result_kind),
    .out_coef_position(out_coef_position),
    .out_coef_value   (out_coef_value),
    .out_block_last   (out_block_last)
  );

endmodule

// ===== bench/tb.sv =====
// Testbench for the non-intra block coefficient decoder: VLC, zigzag, dequantizer.
// Drives bitstream bytes and weight writes and checks every result against a predictor.
// Depends on mibcd_pkg and mpeg1_inter_block_coef_decode_core.
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  pos;
    logic [18:0] value;
    logic        last;
  } coef_result_t;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic               in_mode;
  logic [7:0]         in_data_byte;
  logic [5:0]         in_weight_index;
  logic [7:0]         in_weight_value;
  logic [4:0]         in_quant_scale;
  logic               empty;
  logic               pop;
  logic [1:0]         out_result_kind;
  logic [5:0]         out_coef_position;
  logic signed [18:0] out_coef_value;
  logic               out_block_last;

  mpeg1_inter_block_coef_decode_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_mode          (in_mode),
    .in_data_byte     (in_data_byte),
    .in_weight_index  (in_weight_index),
    .in_weight_value  (in_weight_value),
    .in_quant_scale   (in_quant_scale),
    .empty            (empty),
    .pop              (pop),
    .out_result_kind  (out_result_kind),
    .out_coef_position(out_coef_position),
    .out_coef_value   (out_coef_value),
    .out_block_last   (out_block_last)
  );

  // Predictor state: mirrors the decoder's bit buffer, scan state and weights
  logic [63:0]  pred_bits;
  int unsigned  pred_held;
  int unsigned  pred_scan;
  bit           pred_first;
  logic [7:0]   pred_weight [64];

  coef_result_t pending_results[$];
  bit           stream_bits[$];     // encoded bits waiting to be packed into bytes

  int  error_count;
  int  bytes_sent;
  int  weights_sent;
  int  results_checked;
  int  quiet_cycles;
  bit  no_idle;
  int  pop_stall;

  // Clock: 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] low_ones(int unsigned n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  // Pick the table row for the 16 head bits, from the count of leading zeros
  function automatic mibcd_pkg::vlc_t row_for_code(logic [15:0] code, bit first);
    int lz;
    lz = 0;
    while (lz < 16 && !code[15 - lz]) lz++;
    case (lz)
      0, 1:    return first ? mibcd_pkg::TAB_FIRST[code[15:12] - 4]
                            : mibcd_pkg::TAB_NEXT[code[15:12] - 4];
      2, 3, 4, 5: return mibcd_pkg::TAB_L8[(code >> 8) - 4];
      6:       return mibcd_pkg::TAB_L10[(code >> 6) - 8];
      7:       return mibcd_pkg::TAB_L12[(code >> 4) - 16];
      8:       return mibcd_pkg::TAB_L13[(code >> 3) - 16];
      9:       return mibcd_pkg::TAB_L14[(code >> 2) - 16];
      10:      return mibcd_pkg::TAB_L15[(code >> 1) - 16];
      default: return mibcd_pkg::TAB_L16[code[3:0]];
    endcase
  endfunction

  function automatic void predictor_reset();
    pred_bits  = '0;
    pred_held  = 0;
    pred_scan  = 0;
    pred_first = 1'b1;
    foreach (pred_weight[i]) pred_weight[i] = 8'd16;
  endfunction

  function automatic void queue_result(logic [1:0] kind, logic [5:0] pos,
                                       logic [18:0] value, logic last);
    coef_result_t r;
    r.kind  = kind;
    r.pos   = pos;
    r.value = value;
    r.last  = last;
    pending_results.push_back(r);
  endfunction

  // Decode every complete symbol after one byte, at most eight of them
  function automatic void predict_byte(logic [7:0] data, logic [4:0] qs);
    logic [63:0] acc;
    logic [15:0] head;
    int unsigned held, count, run, mag, total, pos_scan, prod;
    int unsigned b1, b2;
    int          lvl;
    bit          sign, stalled;
    mibcd_pkg::vlc_t row;
    acc = ((pred_bits & low_ones(pred_held)) << 8) | 64'(data);
    held = pred_held + 8;
    count = 0;
    stalled = 0;
    while (count < 8 && !stalled) begin
      head = (held >= 16) ? 16'(acc >> (held - 16)) : 16'(acc << (16 - held));
      if (head < mibcd_pkg::CODE_INVALID) begin
        if (held < 12) begin
          stalled = 1;
        end else begin
          held -= 12;
          queue_result(mibcd_pkg::KIND_INVALID, '0, '0, 1'b1);
          count++;
          pred_scan = 0;
          pred_first = 1;
        end
        continue;
      end
      row = row_for_code(head, pred_first);
      if (row.len > held) begin
        stalled = 1;
        continue;
      end
      if (row.run == mibcd_pkg::RUN_EOB) begin
        held -= row.len;
        queue_result(mibcd_pkg::KIND_EOB, '0, '0, 1'b1);
        count++;
        pred_scan = 0;
        pred_first = 1;
        continue;
      end
      if (row.run == mibcd_pkg::RUN_ESC) begin
        if (held < 20) begin
          stalled = 1;
          continue;
        end
        run = 32'((acc >> (held - 12)) & 64'd63);
        b1 = 32'((acc >> (held - 20)) & 64'd255);
        total = 20;
        if (b1 == 0 || b1 == 128) begin
          if (held < 28) begin
            stalled = 1;
            continue;
          end
          b2 = 32'((acc >> (held - 28)) & 64'd255);
          total = 28;
          lvl = (b1 == 0) ? int'(b2) : int'(b2) - 256;
        end else begin
          lvl = (b1 > 128) ? int'(b1) - 256 : int'(b1);
        end
        sign = lvl < 0;
        mag = sign ? -lvl : lvl;
      end else begin
        if (held < row.len + 1) begin
          stalled = 1;
          continue;
        end
        run = row.run;
        mag = row.level;
        sign = acc[held - row.len - 1];
        total = row.len + 1;
      end
      held -= total;
      count++;
      pos_scan = pred_scan + run;
      if (pos_scan > 63) begin
        queue_result(mibcd_pkg::KIND_OVERFLOW, '0, '0, 1'b1);
        pred_scan = 0;
        pred_first = 1;
      end else begin
        prod = 0;
        if (mag != 0) begin
          prod = ((2 * mag + 1) * qs * pred_weight[mibcd_pkg::ZIGZAG[pos_scan]]) >> 4;
          if (prod != 0) prod = (prod - 1) | 1;
        end
        queue_result(mibcd_pkg::KIND_COEF, mibcd_pkg::ZIGZAG[pos_scan],
                     sign ? 19'(-prod) : 19'(prod), 1'b0);
        pred_scan = pos_scan + 1;
        pred_first = 0;
      end
    end
    pred_bits = acc & low_ones(held) & low_ones(32);
    pred_held = held & 63;
  endfunction

  // Sender-side idle burst at random points, off in the last part of the run
  task automatic maybe_idle();
    int n;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        @(negedge clk);
        push = 1'b0;
      end
    end
  endtask

  // Present one item and hold it until the transfer, then update the predictor
  task automatic send_item(bit mode, logic [7:0] data, logic [5:0] widx,
                           logic [7:0] wval, logic [4:0] qs);
    maybe_idle();
    @(negedge clk);
    push = 1'b1;
    in_mode = mode;
    in_data_byte = data;
    in_weight_index = widx;
    in_weight_value = wval;
    in_quant_scale = qs;
    do @(posedge clk); while (full);
    if (mode) begin
      pred_weight[widx] = wval;
      weights_sent++;
    end else begin
      predict_byte(data, qs);
      bytes_sent++;
    end
  endtask

  task automatic send_byte(logic [7:0] data, logic [4:0] qs);
    send_item(1'b0, data, 6'($urandom), 8'($urandom), qs);
  endtask

  task automatic send_weight(logic [5:0] widx, logic [7:0] wval);
    send_item(1'b1, 8'($urandom), widx, wval, 5'($urandom_range(1, 31)));
  endtask

  // Append n bits, most significant first
  function automatic void put_bits(int unsigned value, int n);
    for (int i = n - 1; i >= 0; i--) stream_bits.push_back(value[i]);
  endfunction

  function automatic void put_escape(int unsigned run, int lvl);
    put_bits(1, 6);
    put_bits(run, 6);
    if (lvl > -128 && lvl < 128 && lvl != 0) begin
      put_bits(8'(lvl), 8);
    end else if (lvl > 0 || lvl == 0) begin
      put_bits(0, 8);
      put_bits(lvl, 8);
    end else begin
      put_bits(128, 8);
      put_bits(lvl + 256, 8);
    end
  endfunction

  // One random run/level code, covering every table, plus its sign bit, or an escape code
  function automatic void put_random_coef();
    int unsigned idx, t;
    mibcd_pkg::vlc_t row;
    case ($urandom_range(0, 5))
      0: begin
        idx = $urandom_range(0, 3);
        row = mibcd_pkg::TAB_NEXT[idx];
        put_bits(((idx + 4) << 12) >> (16 - row.len), row.len);
      end
      1: put_bits(3, 2);
      2: begin
        idx = $urandom_range(4, 59);
        row = mibcd_pkg::TAB_L8[idx];
        put_bits(((idx + 4) << 8) >> (16 - row.len), row.len);
      end
      3, 4: begin
        t = $urandom_range(0, 5);
        idx = (t == 0) ? $urandom_range(0, 7) : $urandom_range(0, 15);
        case (t)
          0: put_bits(idx + 8, 10);
          1: put_bits(idx + 16, 12);
          2: put_bits(idx + 16, 13);
          3: put_bits(idx + 16, 14);
          4: put_bits(idx + 16, 15);
          default: put_bits(idx + 16, 16);
        endcase
      end
      default: begin
        put_escape($urandom_range(0, 63) >> $urandom_range(0, 5),
                   int'($urandom_range(0, 511)) - 256);
        return;
      end
    endcase
    put_bits($urandom_range(0, 1), 1);
  endfunction

  // Pack whole bytes of the stream and send them, with random weight writes mixed in
  task automatic flush_stream(bit mix_weights);
    logic [7:0] b;
    while (stream_bits.size() >= 8) begin
      for (int i = 0; i < 8; i++) b[7 - i] = stream_bits.pop_front();
      send_byte(b, 5'($urandom_range(1, 31)));
      if (mix_weights && $urandom_range(0, 15) == 0)
        send_weight(6'($urandom), 8'($urandom_range(1, 255)));
    end
  endtask

  // Hold the sender until every expected result has been transferred
  task automatic wait_drained();
    @(negedge clk);
    push = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_weight_extremes();
    send_weight(6'd0, 8'd255);
    send_weight(6'd63, 8'd1);
    send_weight(6'd1, 8'd255);
    send_weight(6'd8, 8'd1);
  endtask

  task automatic test_byte_extremes();
    send_byte(8'hFF, 5'd31);   // first-coefficient codes, then later ones
    send_byte(8'h00, 5'd1);
    send_byte(8'h00, 5'd1);    // twelve zeros: invalid code
    send_byte(8'h80, 5'd31);
    send_byte(8'h55, 5'd16);
    send_byte(8'hAA, 5'd15);
  endtask

  task automatic test_escape_levels();
    put_bits(2, 2);            // end the block unless it is still empty
    put_escape(0, 0);          // long form, level zero stays zero
    put_escape(0, 255);
    put_escape(5, -256);
    put_escape(1, 127);
    put_escape(1, -127);
    put_escape(2, -1);
    put_bits(2, 2);
    put_escape(63, 1);         // last position
    put_escape(0, 1);          // beyond 63: overflow
    put_random_coef();
    put_bits(2, 2);
    while (stream_bits.size() % 8 != 0) put_bits(0, 1);
    flush_stream(1'b0);
  endtask

  task automatic test_short_codes_burst();
    // Many two-bit codes in a row, each followed by its sign bit
    put_bits(1, 1);
    put_bits(0, 1);
    repeat (30) put_bits(6, 3);
    put_bits(2, 2);
    while (stream_bits.size() % 8 != 0) put_bits(1, 1);
    flush_stream(1'b0);
  endtask

  task automatic test_random_blocks(int n_bytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      repeat ($urandom_range(0, 12)) put_random_coef();
      case ($urandom_range(0, 19))
        0:       put_bits(0, 12);                         // invalid code
        1:       put_escape($urandom_range(40, 63), 3);  // likely overflow
        default: put_bits(2, 2);                          // end of block
      endcase
      flush_stream(1'b1);
    end
  endtask

  task automatic test_random_noise(int n_bytes);
    repeat (n_bytes) send_byte(8'($urandom), 5'($urandom_range(1, 31)));
    put_bits(0, 12);           // resynchronize to a block start
    put_bits(2, 2);
  endtask

  // Result side: random stall bursts, none in the last part of the run
  always @(negedge clk) begin
    if (!rst_n) begin
      pop = 1'b0;
      pop_stall = 0;
    end else if (pop_stall > 0) begin
      pop = 1'b0;
      pop_stall--;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      pop = 1'b0;
      pop_stall = $urandom_range(1, 3) - 1;
    end else begin
      pop = 1'b1;
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Check every transfer on the result side against the oldest expectation
  always @(posedge clk) begin
    coef_result_t want;
    if (rst_n && pop && !empty) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_result_kind, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind !== want.kind)
          report_mismatch("result_kind", out_result_kind, want.kind);
        if (out_coef_position !== want.pos)
          report_mismatch("coef_position", out_coef_position, want.pos);
        if (out_coef_value !== want.value)
          report_mismatch("coef_value", out_coef_value, $signed(want.value));
        if (out_block_last !== want.last)
          report_mismatch("block_last", out_block_last, want.last);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d quiet cycles", quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    error_count = 0;
    bytes_sent = 0;
    weights_sent = 0;
    results_checked = 0;
    quiet_cycles = 0;
    no_idle = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    pop_stall = 0;
    in_mode = 1'b0;
    in_data_byte = '0;
    in_weight_index = '0;
    in_weight_value = 8'd16;
    in_quant_scale = 5'd1;
    predictor_reset();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_weight_extremes();
    test_byte_extremes();
    test_escape_levels();
    test_short_codes_burst();
    wait_drained();
    test_random_blocks(120);
    test_random_noise(30);
    flush_stream(1'b1);
    wait_drained();
    test_random_blocks(80);
    no_idle = 1'b1;            // last part: no idling on either side
    test_random_blocks(40);

    @(negedge clk);
    push = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d bitstream bytes and %0d weight writes; checked %0d results.",
             bytes_sent, weights_sent, results_checked);
    $display("Covered all code tables, escapes, invalid codes, overflow and stalls.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
